// ===== design/lpht_pkg.sv =====
package lpht_pkg;

    localparam int TABLE_SIZE_DEF = 16;
    localparam int KEY_W = 31;
    localparam int PAY_W = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W = 4;
    localparam int OP_W = 2;

    localparam int RECIP_W = 32;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_REMOVED   = 3'd4,
        STAT_FULL      = 3'd5
    } lpht_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_FINISH
    } lpht_state_t;

    typedef struct packed {
        logic             used;
        logic             tomb;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } lpht_entry_t;

endpackage

// ===== design/lpht_home.sv =====
module lpht_home
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int IDX_W = $clog2(TABLE_SIZE)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [IDX_W-1:0] home
);

    localparam int SHIFT = KEY_W + IDX_W;
    localparam int PROD_W = KEY_W + RECIP_W;
    localparam int QUOT_W = RECIP_W - IDX_W;
    localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(TABLE_SIZE) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0] prod;
    logic [KEY_W-1:0]  back;

    assign prod = PROD_W'(key) * PROD_W'(RECIP);
    assign back = KEY_W'(quot_reg) * KEY_W'(TABLE_SIZE);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        rem_next = rem_reg;
        if (busy_reg)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
            rem_next = IDX_W'(key - back);
        end
        else if (start)
        begin
            busy_next = 1'b1;
            quot_next = prod[PROD_W-1:SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign home = rem_reg;

endmodule

// ===== design/lpht_ram.sv =====
module lpht_ram
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int IDX_W = $clog2(TABLE_SIZE)
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output lpht_entry_t      rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  lpht_entry_t      wr_data
);

    lpht_entry_t mem [TABLE_SIZE];
    lpht_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/linear_probe_hash_table.sv =====
// Open-addressing hash table with linear probing over TABLE_SIZE slots.
// The request channel (req_valid, req_stall) carries opcode, key and
// payload; one beat is taken when req_valid is high and req_stall is low.
// Each request gives exactly one beat on the response channel (rsp_valid,
// rsp_stall) with status, payload_out and slot.
// Requests are handled one at a time. A request is taken, passes
// through the home slot unit (key modulo TABLE_SIZE by a reciprocal
// multiply, then a multiply back and subtract), probes from 1 up to
// TABLE_SIZE slots, each probe one read of the slot memory, and then
// writes back and loads the response register; an unused opcode skips
// hashing and probing.
// After reset the block sweeps the slot memory to mark every slot empty,
// one slot a cycle, with req_stall held high.
// The response register holds its beat while rsp_stall is high; a new
// request may be taken meanwhile, and its result waits until the
// response register is free.
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [OP_W-1:0]     opcode,
    input  logic [KEY_W-1:0]    key,
    input  logic [PAY_W-1:0]    payload,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [PAY_W-1:0]    payload_out,
    output logic [SLOT_W-1:0]   slot
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE);

    lpht_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hit_reg, hit_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic [OP_W-1:0]  op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    lpht_status_t     status_reg, status_next;
    logic [PAY_W-1:0] pout_reg, pout_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic             hash_start;
    logic             hash_done;
    logic [IDX_W-1:0] hash_home;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    lpht_entry_t      rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    lpht_entry_t      wr_data;

    logic             rsp_free;
    logic             accept;
    logic [IDX_W-1:0] idx_inc;

    lpht_home #(
        .TABLE_SIZE(TABLE_SIZE),
        .IDX_W(IDX_W)
    ) u_home (
        .clk(clk),
        .rst_n(rst_n),
        .start(hash_start),
        .key(key_reg),
        .done(hash_done),
        .home(hash_home)
    );

    lpht_ram #(
        .TABLE_SIZE(TABLE_SIZE),
        .IDX_W(IDX_W)
    ) u_ram (
        .clk(clk),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign accept = req_valid && !req_stall;
    assign idx_inc = (idx_reg == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        hit_next = hit_reg;
        free_next = free_reg;
        free_idx_next = free_idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        op_next = op_reg;
        key_next = key_reg;
        pay_next = pay_reg;
        status_next = status_reg;
        pout_next = pout_reg;
        slot_next = slot_reg;
        hash_start = 1'b0;
        rd_en = 1'b0;
        rd_addr = idx_inc;
        wr_en = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                idx_next = idx_inc;
                if (idx_reg == IDX_W'(TABLE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next = opcode;
                    key_next = key;
                    pay_next = payload;
                    hit_next = 1'b0;
                    free_next = 1'b0;
                    if (opcode == OP_INSERT || opcode == OP_LOOKUP || opcode == OP_REMOVE)
                    begin
                        state_next = ST_HASH;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_HASH:
            begin
                hash_start = 1'b1;
                if (hash_done)
                begin
                    hash_start = 1'b0;
                    rd_en = 1'b1;
                    rd_addr = hash_home;
                    idx_next = hash_home;
                    cnt_next = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (rd_data.used && rd_data.key == key_reg)
                begin
                    hit_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (!rd_data.used && !free_reg)
                    begin
                        free_next = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    if ((!rd_data.used && !rd_data.tomb) ||
                        cnt_reg == CNT_W'(TABLE_SIZE - 1))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                        rd_addr = idx_inc;
                        idx_next = idx_inc;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    status_next = STAT_NOT_FOUND;
                    pout_next = '0;
                    slot_next = '0;
                    if (op_reg == OP_INSERT)
                    begin
                        wr_data.used = 1'b1;
                        wr_data.tomb = 1'b0;
                        wr_data.key = key_reg;
                        wr_data.payload = pay_reg;
                        if (hit_reg)
                        begin
                            wr_en = 1'b1;
                            status_next = STAT_UPDATED;
                            slot_next = SLOT_W'(idx_reg);
                        end
                        else if (free_reg)
                        begin
                            wr_en = 1'b1;
                            wr_addr = free_idx_reg;
                            status_next = STAT_INSERTED;
                            slot_next = SLOT_W'(free_idx_reg);
                        end
                        else
                        begin
                            status_next = STAT_FULL;
                        end
                    end
                    else if ((op_reg == OP_LOOKUP || op_reg == OP_REMOVE) && hit_reg)
                    begin
                        pout_next = rd_data.payload;
                        slot_next = SLOT_W'(idx_reg);
                        if (op_reg == OP_LOOKUP)
                        begin
                            status_next = STAT_FOUND;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            wr_data = rd_data;
                            wr_data.used = 1'b0;
                            wr_data.tomb = 1'b1;
                            status_next = STAT_REMOVED;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg <= '0;
            cnt_reg <= '0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            hit_reg <= hit_next;
            free_reg <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_next;
        op_reg <= op_next;
        key_reg <= key_next;
        pay_reg <= pay_next;
        status_reg <= status_next;
        pout_reg <= pout_next;
        slot_reg <= slot_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign status = status_reg;
    assign payload_out = pout_reg;
    assign slot = slot_reg;

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("request beat taken but the controller stayed idle");

    a_write_only_clear_or_finish: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_FINISH))
        else $error("slot memory written outside the clear sweep or write-back");

    a_full_has_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == STAT_FULL) |-> (slot == '0 && payload_out == '0))
        else $error("table full response carries a slot or payload");

    a_result_waits_for_room: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> ($stable(status_reg) && $stable(slot_reg)))
        else $error("pending response overwritten while stalled");
`endif

endmodule
